@@ hw/rtl/irzl_pkg.sv @@
`default_nettype none

package irzl_pkg;

    // request kinds
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_LOOKUP_DONE = 2'd0;
    localparam logic [1:0] ST_INSERTED    = 2'd1;
    localparam logic [1:0] ST_OVERLAP     = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL  = 2'd3;

    // field widths
    localparam int ADDR_W    = 32;
    localparam int END_W     = 33;
    localparam int PLEN_W    = 6;
    localparam int ZONE_W    = 16;
    localparam int MAX_PLEN  = 32;

    // controller to datapath
    typedef struct packed {
        logic start;     // item accepted, latch request
        logic rd_en;     // read one table entry
        logic load_out;  // load the result register
        logic wr_en;     // store the new range
        logic full;      // table holds every entry
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new item
        logic ins_ok;    // insert would succeed
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hw/rtl/irzl_ram.sv @@
`default_nettype none

module irzl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/irzl_ctrl.sv @@
`default_nettype none

module irzl_ctrl #(
    parameter int TABLE_ENTRIES = 64,
    parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire irzl_pkg::t_dp_sts  i_sts,
    output irzl_pkg::t_ctl_cmd      o_cmd,
    output logic [IDX_W-1:0]        o_rd_addr,
    output logic [IDX_W-1:0]        o_wr_addr
);

    import irzl_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        o_cmd   = '0;
        o_cmd.full = (r_count == CNT_W'(TABLE_ENTRIES));
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_idx = '0;
                    n_state = (r_count == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.ins_ok) begin
                        o_cmd.wr_en = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd_addr  = r_idx;
    assign o_wr_addr  = r_count[IDX_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/irzl_dp.sv @@
`default_nettype none

module irzl_dp #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ZONE_BITS = 16,
    parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire irzl_pkg::t_ctl_cmd       i_cmd,
    output irzl_pkg::t_dp_sts             o_sts,
    input  wire logic [IDX_W-1:0]         i_rd_addr,
    input  wire logic [IDX_W-1:0]         i_wr_addr,
    input  wire logic                     i_req_type,
    input  wire logic [irzl_pkg::ADDR_W-1:0] i_address,
    input  wire logic [irzl_pkg::PLEN_W-1:0] i_prefix_length,
    input  wire logic [irzl_pkg::ZONE_W-1:0] i_zone_id,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_zone_found,
    output logic [irzl_pkg::ZONE_W-1:0]   o_found_zone_id,
    output logic [1:0]                    o_status
);

    import irzl_pkg::*;

    localparam int ZW    = (ZONE_BITS < ZONE_W) ? ZONE_BITS : ZONE_W;
    localparam int ENT_W = ADDR_W + END_W + ZW;

    // latched request
    logic              r_insert;
    logic [END_W-1:0]  r_lo;
    logic [END_W-1:0]  r_hi;
    logic [ZW-1:0]     r_zone_in;

    // scan state
    logic              r_chk;
    logic              r_hit;
    logic [ZW-1:0]     r_hit_zone;

    // range of the incoming item
    logic [PLEN_W-1:0] plen_sat;
    logic [END_W-1:0]  span;
    logic [END_W-1:0]  lo_in;
    logic [END_W-1:0]  hi_in;

    always_comb begin
        plen_sat = (i_prefix_length > PLEN_W'(MAX_PLEN)) ? PLEN_W'(MAX_PLEN)
                                                         : i_prefix_length;
        if (i_req_type == REQ_LOOKUP) begin
            span  = END_W'(1);
            lo_in = {1'b0, i_address};
        end else if (plen_sat == '0) begin
            span  = END_W'(1) << MAX_PLEN;
            lo_in = '0;
        end else begin
            span  = END_W'(1) << (PLEN_W'(MAX_PLEN) - plen_sat);
            lo_in = {1'b0, i_address};
        end
        hi_in = lo_in + span;
    end

    // table storage, one entry read per cycle
    logic [ENT_W-1:0]  rd_data;
    logic [ADDR_W-1:0] ent_start;
    logic [END_W-1:0]  ent_end;
    logic [ZW-1:0]     ent_zone;
    logic              match;

    irzl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data ({r_lo[ADDR_W-1:0], r_hi, r_zone_in}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    assign ent_start = rd_data[ENT_W-1 -: ADDR_W];
    assign ent_end   = rd_data[ZW +: END_W];
    assign ent_zone  = rd_data[ZW-1:0];

    // half-open overlap; a lookup is the one-address range
    assign match = (r_lo < ent_end) && ({1'b0, ent_start} < r_hi);

    // request latch and scan result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_insert  <= i_req_type;
            r_lo      <= lo_in;
            r_hi      <= hi_in;
            r_zone_in <= i_zone_id[ZW-1:0];
        end
        if (!i_cmd.start && r_chk && match) begin
            r_hit_zone <= ent_zone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_chk <= i_cmd.rd_en;
            if (i_cmd.start) begin
                r_hit <= 1'b0;
            end else if (r_chk && match) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_sts.out_free = !o_out_valid || !i_out_stall;
    assign o_sts.ins_ok   = r_insert && !i_cmd.full && !r_hit;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_zone_found    <= !r_insert && r_hit;
            o_found_zone_id <= (!r_insert && r_hit) ? ZONE_W'(r_hit_zone) : '0;
            if (!r_insert) begin
                o_status <= ST_LOOKUP_DONE;
            end else if (i_cmd.full) begin
                o_status <= ST_TABLE_FULL;
            end else if (r_hit) begin
                o_status <= ST_OVERLAP;
            end else begin
                o_status <= ST_INSERTED;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ip_range_zone_lookup_unit.sv @@
// an accepted item latches its request, then the table ram is scanned one entry a cycle
// over the stored ranges; the last read drains and the result register loads once it is free;
// an empty table skips scan and drain; one item at a time, input stalls until the result loads
// reset: entry count and handshake state cleared; table ram contents stay undefined,
// entries at or above the count are never read, so no clearing pass is run
`default_nettype none

module ip_range_zone_lookup_unit #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ZONE_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_req_type,
    input  wire logic [irzl_pkg::ADDR_W-1:0] i_address,
    input  wire logic [irzl_pkg::PLEN_W-1:0] i_prefix_length,
    input  wire logic [irzl_pkg::ZONE_W-1:0] i_zone_id,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_zone_found,
    output logic [irzl_pkg::ZONE_W-1:0]      o_found_zone_id,
    output logic [1:0]                       o_status
);

    import irzl_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_ctl_cmd         cmd;
    t_dp_sts          sts;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // sequencer: scan and table fill count
    irzl_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    // range compare, table storage and result register
    irzl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ZONE_BITS     (ZONE_BITS),
        .IDX_W         (IDX_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rd_addr       (rd_addr),
        .i_wr_addr       (wr_addr),
        .i_req_type      (i_req_type),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .i_zone_id       (i_zone_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_zone_found    (o_zone_found),
        .o_found_zone_id (o_found_zone_id),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire

@@ bench/ip_range_zone_lookup_unit_test.sv @@
`default_nettype none

module ip_range_zone_lookup_unit_test;
    import irzl_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int RANDOM_ITEMS  = 600;
    localparam int DRAIN_CYCLES  = 80;

    typedef struct packed {
        logic              found;
        logic [ZONE_W-1:0] zone;
        logic [1:0]        status;
    } t_zone_result;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              i_req_type      = REQ_LOOKUP;
    logic [ADDR_W-1:0] i_address       = '0;
    logic [PLEN_W-1:0] i_prefix_length = '0;
    logic [ZONE_W-1:0] i_zone_id       = '0;
    logic              i_out_stall     = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_zone_found;
    logic [ZONE_W-1:0] o_found_zone_id;
    logic [1:0]        o_status;

    // mirror of the range table, entries fill in order
    logic [ADDR_W-1:0] range_lo_mirror   [TABLE_ENTRIES];
    logic [END_W-1:0]  range_hi_mirror   [TABLE_ENTRIES];
    logic [ZONE_W-1:0] range_zone_mirror [TABLE_ENTRIES];
    int                ranges_stored = 0;

    t_zone_result results_due[$];
    int           error_count = 0;

    // receiver stall pattern state
    int stall_mode = 0;
    int stall_left = 0;

    ip_range_zone_lookup_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ZONE_BITS(ZONE_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_req_type(i_req_type),
        .i_address(i_address),
        .i_prefix_length(i_prefix_length),
        .i_zone_id(i_zone_id),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_zone_found(o_zone_found),
        .o_found_zone_id(o_found_zone_id),
        .o_status(o_status)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // expected result of one item, updates the mirror on a successful insert
    function automatic t_zone_result predict_zone_result(input logic kind,
                                                         input logic [ADDR_W-1:0] addr,
                                                         input logic [PLEN_W-1:0] plen,
                                                         input logic [ZONE_W-1:0] zone);
        t_zone_result      res;
        logic [PLEN_W-1:0] len;
        logic [END_W-1:0]  lo;
        logic [END_W-1:0]  hi;
        logic              clash;
        res   = '{found: 1'b0, zone: '0, status: ST_LOOKUP_DONE};
        clash = 1'b0;
        if (kind == REQ_LOOKUP) begin
            // stored ranges are disjoint, so at most one matches
            for (int i = 0; i < ranges_stored; i++) begin
                if (!res.found && {1'b0, addr} >= {1'b0, range_lo_mirror[i]}
                        && {1'b0, addr} < range_hi_mirror[i]) begin
                    res.found = 1'b1;
                    res.zone  = range_zone_mirror[i];
                end
            end
        end else begin
            // saturate the length, length zero spans the whole space
            len = (plen > MAX_PLEN) ? PLEN_W'(MAX_PLEN) : plen;
            if (len == 0) begin
                lo = '0;
                hi = {1'b1, {ADDR_W{1'b0}}};
            end else begin
                lo = {1'b0, addr};
                hi = lo + (END_W'(1) << (MAX_PLEN - len));
            end
            if (ranges_stored >= TABLE_ENTRIES) begin
                res.status = ST_TABLE_FULL;
            end else begin
                for (int i = 0; i < ranges_stored; i++) begin
                    if (lo < range_hi_mirror[i] && {1'b0, range_lo_mirror[i]} < hi)
                        clash = 1'b1;
                end
                if (clash) begin
                    res.status = ST_OVERLAP;
                end else begin
                    range_lo_mirror[ranges_stored]   = lo[ADDR_W-1:0];
                    range_hi_mirror[ranges_stored]   = hi;
                    range_zone_mirror[ranges_stored] = zone;
                    ranges_stored++;
                    res.status = ST_INSERTED;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
        error_count++;
    endtask

    // present one item and hold it until accepted, called at a rising edge
    task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr,
                             input logic [PLEN_W-1:0] plen, input logic [ZONE_W-1:0] zone);
        i_in_valid      <= 1'b1;
        i_req_type      <= kind;
        i_address       <= addr;
        i_prefix_length <= plen;
        i_zone_id       <= zone;
        do @(posedge i_clk); while (o_in_stall);
        results_due.push_back(predict_zone_result(kind, addr, plen, zone));
    endtask

    task automatic idle_input(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // hold off the sender until every expected result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    // lookups on an empty table miss
    task automatic test_empty_table();
        send_item(REQ_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'hffff_ffff, 6'd63, 16'hffff);
    endtask

    // aligned, unaligned, oversized length and end past the address space
    task automatic test_insert_shapes();
        send_item(REQ_INSERT, 32'h0a00_0000, 6'd8, 16'h0001);
        send_item(REQ_INSERT, 32'hffff_ff00, 6'd8, 16'hffff);
        send_item(REQ_INSERT, 32'hc0a8_0005, 6'd30, 16'h1234);
        send_item(REQ_INSERT, 32'h7fff_ffff, 6'd45, 16'h8000);
        send_item(REQ_INSERT, 32'h0000_0000, 6'd63, 16'h0000);
    endtask

    // hits and misses on either side of several range edges
    task automatic test_lookup_edges();
        send_item(REQ_LOOKUP, 32'h0a00_0000, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'h0aff_ffff, 6'd32, 16'hffff);
        send_item(REQ_LOOKUP, 32'h09ff_ffff, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'h0b00_0000, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'hffff_ffff, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'hc0a8_0008, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'hc0a8_0009, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'h7fff_ffff, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'h8000_0000, 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
    endtask

    // nested, enclosing, whole space and partial clashes, then a touching range
    task automatic test_overlap_rejects();
        send_item(REQ_INSERT, 32'h0a10_0000, 6'd16, 16'h0002);
        send_item(REQ_INSERT, 32'h0800_0000, 6'd6, 16'h0003);
        send_item(REQ_INSERT, 32'h1234_5678, 6'd0, 16'h0004);
        send_item(REQ_INSERT, 32'hc0a8_0000, 6'd29, 16'h0005);
        send_item(REQ_INSERT, 32'h0b00_0000, 6'd8, 16'h00ff);
        wait_for_results();
    endtask

    // mostly lookups aimed at stored ranges, inserts that fill the table
    task automatic test_random_traffic();
        int                burst_left;
        int                gap;
        int                pick;
        int                j;
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
        logic [ZONE_W-1:0] zone;
        logic [END_W-1:0]  base;
        logic [END_W-1:0]  span;
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // bursts with random gaps, some long bursts with no gap at all
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    burst_left = 40;
                    gap        = 0;
                end else begin
                    burst_left = $urandom_range(1, 10);
                    gap        = $urandom_range(0, 8);
                end
                if (gap > 0)
                    idle_input(gap);
            end
            burst_left--;

            zone = ZONE_W'($urandom);
            plen = PLEN_W'($urandom);
            addr = $urandom;
            j    = $urandom_range(0, ranges_stored - 1);
            base = {1'b0, range_lo_mirror[j]};
            span = range_hi_mirror[j] - base;
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                kind = REQ_INSERT;
                if (pick < 12) begin
                    // fresh small range, rarely clashes
                    plen = PLEN_W'($urandom_range(18, MAX_PLEN));
                end else if (pick >= 16 && pick < 19) begin
                    // base inside a stored range
                    addr = ADDR_W'(base + ({1'b0, $urandom} % span));
                end else if (pick >= 19) begin
                    // wide range reaching over a stored one from below
                    addr = range_lo_mirror[j] - $urandom_range(1, 4096);
                    plen = PLEN_W'($urandom_range(1, 19));
                end
            end else begin
                kind = REQ_LOOKUP;
                if (pick < 65) begin
                    addr = ADDR_W'(base + ({1'b0, $urandom} % span));
                end else if (pick < 75) begin
                    case ($urandom_range(0, 2))
                        0: addr = range_lo_mirror[j] - 1;
                        1: addr = ADDR_W'(range_hi_mirror[j] - END_W'(1));
                        default: addr = range_hi_mirror[j][ADDR_W-1:0];
                    endcase
                end
            end
            send_item(kind, addr, plen, zone);
        end
        wait_for_results();
    endtask

    // fill every slot, then inserts report full even when they clash
    task automatic test_table_full();
        int tries;
        tries = 0;
        while (ranges_stored < TABLE_ENTRIES && tries < 500) begin
            send_item(REQ_INSERT, $urandom, PLEN_W'($urandom_range(24, MAX_PLEN)),
                      ZONE_W'($urandom));
            tries++;
        end
        send_item(REQ_INSERT, range_lo_mirror[0], 6'd8, 16'h7777);
        send_item(REQ_INSERT, $urandom, 6'd0, 16'h0001);
        send_item(REQ_INSERT, $urandom, 6'd63, 16'hfffe);
        send_item(REQ_LOOKUP, range_lo_mirror[TABLE_ENTRIES-1], 6'd0, 16'h0000);
        send_item(REQ_LOOKUP, $urandom, 6'd0, 16'h0000);
    endtask

    // receiver stall, switching between quiet, light, heavy and periodic phases
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ((stall_left % 8) < 5);
        endcase
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_zone_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result status", 32'(o_status), 32'hffff_ffff);
            end else begin
                want = results_due.pop_front();
                if (o_zone_found !== want.found)
                    report_mismatch("zone_found", 32'(o_zone_found), 32'(want.found));
                if (o_found_zone_id !== want.zone)
                    report_mismatch("found_zone_id", 32'(o_found_zone_id), 32'(want.zone));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
            end
        end
    end

    // test sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_insert_shapes();
        test_lookup_edges();
        test_overlap_rejects();
        test_random_traffic();
        test_table_full();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/irzl_pkg.sv
hw/rtl/irzl_ram.sv
hw/rtl/irzl_ctrl.sv
hw/rtl/irzl_dp.sv
hw/rtl/ip_range_zone_lookup_unit.sv
bench/ip_range_zone_lookup_unit_test.sv
